// ----- sv/vlgd_pkg.sv -----
// shared types, constants and helpers of the video line group decoder
`default_nettype none

package vlgd_pkg;

    localparam int GROUPS_PER_LINE = 48;

    localparam logic [7:0] MODE_BLANK       = 8'h00;
    localparam logic [7:0] MODE_SOLID       = 8'h01;
    localparam logic [7:0] MODE_HALVES      = 8'h02;
    localparam logic [7:0] MODE_BITMAP      = 8'h03;
    localparam logic [7:0] MODE_QUARTERS    = 8'h04;
    localparam logic [7:0] MODE_DUAL_BITMAP = 8'h06;
    localparam logic [7:0] MODE_EIGHTHS     = 8'h08;

    typedef struct packed {
        logic       ok;
        logic [3:0] len;
    } plen_t;

    typedef struct packed {
        logic [63:0] left;
        logic [63:0] right;
        logic [5:0]  group;
        logic        line_end;
        logic        fill;
        logic        run_last;
    } result_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_FILL = 2'b10
    } fill_state_t;

    function automatic plen_t payload_len(input logic [7:0] m);
        plen_t r;
        r.ok  = 1'b1;
        r.len = 4'd0;
        case (m)
            MODE_BLANK:       r.len = 4'd0;
            MODE_SOLID:       r.len = 4'd1;
            MODE_HALVES:      r.len = 4'd2;
            MODE_BITMAP:      r.len = 4'd3;
            MODE_QUARTERS:    r.len = 4'd4;
            MODE_DUAL_BITMAP: r.len = 4'd6;
            MODE_EIGHTHS:     r.len = 4'd8;
            default:          r.ok  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/vlgd_pixel_decode.sv -----
// pixel formation of one 16-pixel group from mode and payload bytes
`default_nettype none

module vlgd_pixel_decode (
    input  logic [7:0]  mode,
    input  logic [63:0] payload,
    output logic [63:0] left,
    output logic [63:0] right
);
    import vlgd_pkg::*;

    logic [7:0] px [16];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            px[i] = 8'd0;
            case (mode)
                MODE_SOLID:    px[i] = payload[7:0];
                MODE_HALVES:   px[i] = payload[8*(i/8) +: 8];
                MODE_QUARTERS: px[i] = payload[8*(i/4) +: 8];
                MODE_EIGHTHS:  px[i] = payload[8*(i/2) +: 8];
                MODE_BITMAP:
                begin
                    // each bitmap bit covers two pixels, msb first
                    px[i] = payload[23 - i/2] ? payload[15:8] : payload[7:0];
                end
                MODE_DUAL_BITMAP:
                begin
                    if (i < 8)
                    begin
                        px[i] = payload[23 - i] ? payload[15:8] : payload[7:0];
                    end
                    else
                    begin
                        px[i] = payload[47 - (i - 8)] ? payload[39:32] : payload[31:24];
                    end
                end
                default:       px[i] = 8'd0;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            left[8*i +: 8]  = px[i];
            right[8*i +: 8] = px[i + 8];
        end
    end

endmodule

`default_nettype wire

// ----- sv/vlgd_ctrl.sv -----
// decoder state, byte phase, group count and zero-fill sequencing
`default_nettype none

module vlgd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [7:0]        item_byte,
    input  logic              item_line_start,
    input  logic              out_free,
    output logic              advance,
    output logic              res_valid,
    output vlgd_pkg::result_t res
);
    import vlgd_pkg::*;

    fill_state_t state_reg, state_next;
    logic [7:0]  mode_reg, mode_next;
    logic [3:0]  phase_reg, phase_next;
    logic [63:0] payload_reg, payload_next;
    logic [5:0]  groups_reg, groups_next;
    logic        finished_reg, finished_next;

    logic        eff_finished;
    logic [5:0]  eff_groups;
    logic [3:0]  eff_phase;
    logic [63:0] eff_payload;
    logic [63:0] merged;
    plen_t       blen;
    plen_t       mlen;
    logic        phase0;
    logic        done_group;
    logic        produces;
    logic        fill_flag;
    logic [5:0]  cur_groups;
    logic [6:0]  groups_inc;
    logic        at_end;
    logic [7:0]  dec_mode;
    logic [63:0] dec_left;
    logic [63:0] dec_right;

    // a line start drops any partial group before the byte is looked at
    always_comb
    begin
        eff_finished = item_line_start ? 1'b0 : finished_reg;
        eff_groups   = item_line_start ? 6'd0 : groups_reg;
        eff_phase    = item_line_start ? 4'd0 : phase_reg;
        eff_payload  = item_line_start ? 64'd0 : payload_reg;
        blen         = payload_len(item_byte);
        mlen         = payload_len(mode_reg);
        phase0       = (eff_phase == 4'd0);
        merged       = eff_payload |
                       ({56'd0, item_byte} << {3'(eff_phase[2:0] - 3'd1), 3'b000});
        done_group   = !phase0 && (eff_phase >= mlen.len);
        produces     = !eff_finished &&
                       (phase0 ? (!blen.ok || (blen.len == 4'd0)) : done_group);
        fill_flag    = (state_reg == ST_FILL) || (phase0 && !blen.ok);
        cur_groups   = (state_reg == ST_FILL) ? groups_reg : eff_groups;
        groups_inc   = {1'b0, cur_groups} + 7'd1;
        at_end       = groups_inc >= 7'(GROUPS_PER_LINE);
        dec_mode     = phase0 ? item_byte : mode_reg;
    end

    vlgd_pixel_decode u_decode (
        .mode    (dec_mode),
        .payload (merged),
        .left    (dec_left),
        .right   (dec_right)
    );

    always_comb
    begin
        res.left     = fill_flag ? 64'd0 : dec_left;
        res.right    = fill_flag ? 64'd0 : dec_right;
        res.group    = cur_groups;
        res.line_end = at_end;
        res.fill     = fill_flag;
        res.run_last = fill_flag ? at_end : 1'b1;
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        phase_next    = phase_reg;
        payload_next  = payload_reg;
        groups_next   = groups_reg;
        finished_next = finished_reg;
        advance       = 1'b0;
        res_valid     = 1'b0;
        case (state_reg)
            ST_FILL:
            begin
                res_valid = out_free;
                if (out_free)
                begin
                    groups_next = at_end ? 6'd0 : groups_inc[5:0];
                    if (at_end)
                    begin
                        finished_next = 1'b1;
                        state_next    = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                advance = item_valid && (!produces || out_free);
                if (advance)
                begin
                    finished_next = eff_finished;
                    groups_next   = eff_groups;
                    phase_next    = eff_phase;
                    payload_next  = eff_payload;
                    if (!eff_finished)
                    begin
                        if (phase0)
                        begin
                            mode_next    = item_byte;
                            payload_next = 64'd0;
                            if (!blen.ok || (blen.len == 4'd0))
                            begin
                                res_valid     = 1'b1;
                                groups_next   = at_end ? 6'd0 : groups_inc[5:0];
                                finished_next = at_end;
                                // invalid mode: the remaining groups follow one per cycle while the output is free
                                if (!blen.ok && !at_end)
                                begin
                                    state_next = ST_FILL;
                                end
                            end
                            else
                            begin
                                phase_next = 4'd1;
                            end
                        end
                        else
                        begin
                            payload_next = merged;
                            if (done_group)
                            begin
                                phase_next    = 4'd0;
                                res_valid     = 1'b1;
                                groups_next   = at_end ? 6'd0 : groups_inc[5:0];
                                finished_next = at_end;
                            end
                            else
                            begin
                                phase_next = eff_phase + 4'd1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RUN;
            mode_reg     <= 8'd0;
            phase_reg    <= 4'd0;
            payload_reg  <= 64'd0;
            groups_reg   <= 6'd0;
            finished_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            phase_reg    <= phase_next;
            payload_reg  <= payload_next;
            groups_reg   <= groups_next;
            finished_reg <= finished_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/video_line_group_decoder.sv -----
// top level: input register, decoder control, result register
// a byte reaches the outputs through the input register and then the result register
// throughput: one byte per cycle; a byte that yields a result waits for a free output,
// one that yields none does not. An invalid mode byte holds off input while the
// line's remaining groups leave as zero fill, one per cycle while the output is free
// reset clears all control state; the decoder then ignores bytes until a line start
`default_nettype none

module video_line_group_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  code_byte,
    input  logic        line_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] pixels_left,
    output logic [63:0] pixels_right,
    output logic [5:0]  group_number,
    output logic        line_end,
    output logic        bad_mode_fill,
    output logic        run_last
);
    import vlgd_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_ls_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;

    logic       in_take;
    logic       out_free;
    logic       advance;
    logic       res_valid;
    result_t    res;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    vlgd_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (in_valid_reg),
        .item_byte       (in_byte_reg),
        .item_line_start (in_ls_reg),
        .out_free        (out_free),
        .advance         (advance),
        .res_valid       (res_valid),
        .res             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= code_byte;
            in_ls_reg   <= line_start;
        end
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixels_left   = out_reg.left;
    assign pixels_right  = out_reg.right;
    assign group_number  = out_reg.group;
    assign line_end      = out_reg.line_end;
    assign bad_mode_fill = out_reg.fill;
    assign run_last      = out_reg.run_last;

    // a zero-fill run ends exactly at the end of the line
    a_fill_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_mode_fill |-> run_last == line_end)
        else $error("fill run_last does not match line_end");

    // a decoded group is always the only result of its byte
    a_group_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_mode_fill |-> run_last)
        else $error("decoded group without run_last");

    // a taken fill group that does not end the line is followed at once by the next one
    a_fill_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && bad_mode_fill && !line_end |=>
            out_valid && bad_mode_fill && (group_number == $past(group_number) + 6'd1))
        else $error("zero-fill run broken");

    // no byte transaction while a zero-fill run is still pending
    a_fill_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_mode_fill && !line_end && in_valid_reg |-> in_stall)
        else $error("input moved during zero fill");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// testbench for the video line group decoder: directed and random byte streams
`timescale 1ns / 100ps

module tb;
    import vlgd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 240;
    localparam int HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  code_byte = 8'h00;
    logic        line_start = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] pixels_left;
    logic [63:0] pixels_right;
    logic [5:0]  group_number;
    logic        line_end;
    logic        bad_mode_fill;
    logic        run_last;

    video_line_group_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .code_byte     (code_byte),
        .line_start    (line_start),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixels_left   (pixels_left),
        .pixels_right  (pixels_right),
        .group_number  (group_number),
        .line_end      (line_end),
        .bad_mode_fill (bad_mode_fill),
        .run_last      (run_last)
    );

    class line_decode_board;
        logic [7:0]  mode;
        logic [3:0]  phase;
        logic [63:0] payload;
        logic [5:0]  groups_done;
        logic        finished;
        result_t     awaited_groups[$];
        int          errors;
        int          bytes_taken;
        int          bytes_dropped;
        int          groups_checked;
        int          fills_checked;
        int          line_ends_checked;

        function new();
            mode = 8'h00;
            phase = 4'd0;
            payload = 64'd0;
            groups_done = 6'd0;
            finished = 1'b1;
            errors = 0;
            bytes_taken = 0;
            bytes_dropped = 0;
            groups_checked = 0;
            fills_checked = 0;
            line_ends_checked = 0;
        endfunction

        // payload length of a mode, -1 for a mode the decoder rejects
        function int group_len(logic [7:0] m);
            case (m)
                MODE_BLANK:       return 0;
                MODE_SOLID:       return 1;
                MODE_HALVES:      return 2;
                MODE_BITMAP:      return 3;
                MODE_QUARTERS:    return 4;
                MODE_DUAL_BITMAP: return 6;
                MODE_EIGHTHS:     return 8;
                default:          return -1;
            endcase
        endfunction

        function logic [7:0] pb(int k);
            return payload[8*k +: 8];
        endfunction

        function logic [127:0] decode_pixels();
            logic [127:0] pix;
            logic [7:0]   c;
            int           i;
            pix = '0;
            for (i = 0; i < 16; i++)
            begin
                case (mode)
                    MODE_SOLID:       c = pb(0);
                    MODE_HALVES:      c = pb(i / 8);
                    MODE_BITMAP:      c = payload[23 - i / 2] ? pb(1) : pb(0);
                    MODE_QUARTERS:    c = pb(i / 4);
                    MODE_DUAL_BITMAP:
                    begin
                        if (i < 8)
                            c = payload[23 - i] ? pb(1) : pb(0);
                        else
                            c = payload[55 - i] ? pb(4) : pb(3);
                    end
                    MODE_EIGHTHS:     c = pb(i / 2);
                    default:          c = 8'h00;
                endcase
                pix[8*i +: 8] = c;
            end
            return pix;
        endfunction

        function void push_group(logic [127:0] pix, logic fill, logic last);
            result_t r;
            logic    done;
            done = (int'(groups_done) + 1 >= GROUPS_PER_LINE);
            r.left = pix[63:0];
            r.right = pix[127:64];
            r.group = groups_done;
            r.line_end = done;
            r.fill = fill;
            r.run_last = last;
            awaited_groups.push_back(r);
            groups_done = groups_done + 6'd1;
            if (done)
            begin
                finished = 1'b1;
                groups_done = 6'd0;
            end
        endfunction

        // input transaction accepted: advance the decoder state
        function void take_byte(logic [7:0] b, logic ls);
            int len;
            bytes_taken++;
            if (ls)
            begin
                finished = 1'b0;
                groups_done = 6'd0;
                phase = 4'd0;
                payload = 64'd0;
            end
            if (finished)
            begin
                bytes_dropped++;
                return;
            end
            if (phase == 4'd0)
            begin
                len = group_len(b);
                mode = b;
                payload = 64'd0;
                if (len < 0)
                begin
                    // rest of the line leaves as zero fill
                    while (!finished)
                        push_group('0, 1'b1, int'(groups_done) + 1 >= GROUPS_PER_LINE);
                end
                else if (len == 0)
                    push_group('0, 1'b0, 1'b1);
                else
                    phase = 4'd1;
                return;
            end
            len = group_len(mode);
            payload = payload | (64'(b) << (8 * (int'(phase) - 1)));
            if (int'(phase) >= len)
            begin
                phase = 4'd0;
                push_group(decode_pixels(), 1'b0, 1'b1);
            end
            else
                phase = phase + 4'd1;
        endfunction

        function void check_field(string what, logic [63:0] want, logic [63:0] seen);
            if (want !== seen)
            begin
                errors++;
                $display("%0t: %s expected %h, actual %h", $time, what, want, seen);
            end
        endfunction

        // output transaction accepted: compare with the oldest awaited group
        function void match_group(result_t seen);
            result_t want;
            if (awaited_groups.size() == 0)
            begin
                errors++;
                $display("%0t: group %0d arrived with none outstanding", $time, seen.group);
                return;
            end
            want = awaited_groups.pop_front();
            check_field("pixels_left", want.left, seen.left);
            check_field("pixels_right", want.right, seen.right);
            check_field("group_number", 64'(want.group), 64'(seen.group));
            check_field("line_end", 64'(want.line_end), 64'(seen.line_end));
            check_field("bad_mode_fill", 64'(want.fill), 64'(seen.fill));
            check_field("run_last", 64'(want.run_last), 64'(seen.run_last));
            groups_checked++;
            if (seen.fill)
                fills_checked++;
            if (seen.line_end)
                line_ends_checked++;
        endfunction
    endclass

    line_decode_board board = new();

    logic       calm = 1'b0;
    logic       hold_request = 1'b0;
    int         hold_left = 0;
    int         cycle_count = 0;
    int         rand_bytes = 0;
    int         line_groups = 0;
    logic       line_done = 1'b1;
    logic       need_start = 1'b1;
    logic [8:0] opening[$];

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("tb failed");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 10);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.take_byte(code_byte, line_start);
    end

    always @(posedge clk)
    begin
        result_t seen;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.left = pixels_left;
            seen.right = pixels_right;
            seen.group = group_number;
            seen.line_end = line_end;
            seen.fill = bad_mode_fill;
            seen.run_last = run_last;
            board.match_group(seen);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic ls);
        int gap;
        if (!calm && $urandom_range(99) < 4)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        code_byte <= b;
        line_start <= ls;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [7:0] payload_byte();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 8'h00;
        if (r < 20)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_mode();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return MODE_BLANK;
        case (r % 6)
            0:       return MODE_SOLID;
            1:       return MODE_HALVES;
            2:       return MODE_BITMAP;
            3:       return MODE_QUARTERS;
            4:       return MODE_DUAL_BITMAP;
            default: return MODE_EIGHTHS;
        endcase
    endfunction

    function automatic logic [7:0] pick_bad_mode();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (board.group_len(b) >= 0)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    task automatic send_group(input logic [7:0] m, input logic ls);
        int n;
        int k;
        n = board.group_len(m);
        if (ls)
        begin
            line_groups = 0;
            line_done = 1'b0;
        end
        send_byte(m, ls);
        for (k = 0; k < n; k++)
            send_byte(payload_byte(), 1'b0);
        rand_bytes += n + 1;
        line_groups++;
        if (line_groups == GROUPS_PER_LINE)
            line_done = 1'b1;
    endtask

    initial
    begin
        int         kind;
        int         n;
        logic       ls;
        logic [7:0] m;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every mode with edge payloads, then restart mid-group and bad modes
        opening = '{
            {1'b0, 8'hFF},
            {1'b1, MODE_BLANK},
            {1'b0, MODE_SOLID}, {1'b0, 8'hFF},
            {1'b0, MODE_HALVES}, {1'b0, 8'h00}, {1'b0, 8'hFF},
            {1'b0, MODE_BITMAP}, {1'b0, 8'h11}, {1'b0, 8'hEE}, {1'b0, 8'hA5},
            {1'b0, MODE_QUARTERS}, {1'b0, 8'h00}, {1'b0, 8'h80}, {1'b0, 8'h7F},
            {1'b0, 8'hFF},
            {1'b0, MODE_DUAL_BITMAP}, {1'b0, 8'h10}, {1'b0, 8'h20}, {1'b0, 8'hF0},
            {1'b0, 8'h30}, {1'b0, 8'h40}, {1'b0, 8'h0F},
            {1'b0, MODE_EIGHTHS}, {1'b0, 8'h01}, {1'b0, 8'h23}, {1'b0, 8'h45},
            {1'b0, 8'h67}, {1'b0, 8'h89}, {1'b0, 8'hAB}, {1'b0, 8'hCD}, {1'b0, 8'hEF},
            {1'b0, MODE_DUAL_BITMAP}, {1'b0, 8'hAA},
            {1'b1, 8'h05},
            {1'b0, MODE_SOLID},
            {1'b1, MODE_BLANK}, {1'b0, MODE_BLANK}, {1'b0, 8'hFF}
        };
        foreach (opening[i])
            send_byte(opening[i][7:0], opening[i][8]);

        line_done = 1'b1;
        need_start = 1'b1;
        line_groups = 0;
        hold_request = 1'b1;

        while (rand_bytes < RANDOM_BYTES)
        begin
            calm = (rand_bytes >= 100 && rand_bytes < 160);
            ls = need_start;
            // bytes while the line is over are dropped by the decoder
            if (line_done && $urandom_range(99) < 30)
            begin
                n = $urandom_range(1, 3);
                repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
            end
            kind = $urandom_range(99);
            if (!ls && line_groups > 0 && kind < 3)
                ls = 1'b1;
            if (kind >= 3 && kind < 9)
            begin
                // group cut short, next byte restarts the line
                m = pick_mode();
                if (m == MODE_BLANK)
                    m = MODE_EIGHTHS;
                n = $urandom_range(0, board.group_len(m) - 1);
                if (ls)
                begin
                    line_groups = 0;
                    line_done = 1'b0;
                end
                send_byte(m, ls);
                repeat (n) send_byte(payload_byte(), 1'b0);
                rand_bytes += n + 1;
                need_start = 1'b1;
            end
            else if (kind >= 9 && kind < 14)
            begin
                send_byte(pick_bad_mode(), ls);
                rand_bytes++;
                line_groups = 0;
                line_done = 1'b1;
                need_start = 1'b1;
            end
            else if (kind >= 14 && kind < 26)
            begin
                n = $urandom_range(4, 24);
                repeat (n)
                begin
                    send_group(MODE_BLANK, ls);
                    ls = 1'b0;
                    if (line_done)
                        break;
                end
                need_start = line_done;
            end
            else
            begin
                send_group(pick_mode(), ls);
                need_start = line_done;
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (board.awaited_groups.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d bytes accepted, %0d dropped outside a line, in %0d cycles",
                 board.bytes_taken, board.bytes_dropped, cycle_count);
        $display("%0d groups checked: %0d zero fill, %0d line ends",
                 board.groups_checked, board.fills_checked, board.line_ends_checked);
        if (board.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/vlgd_pkg.sv
sv/vlgd_pixel_decode.sv
sv/vlgd_ctrl.sv
sv/video_line_group_decoder.sv
sim/tb.sv
